// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// File: sv/egsc_pkg.sv
package egsc_pkg;
  localparam int unsigned GridWDef = 64;
  localparam int unsigned GridHDef = 64;
  localparam int unsigned AngleMax = 102944;
  localparam int unsigned Sqrt2Q16 = 92682;
  localparam int unsigned CordicSteps = 17;
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_FALL_W    = 3'd3,
    REG_RISE_W    = 3'd4,
    REG_CAUTION   = 3'd5,
    REG_LETHAL    = 3'd6,
    REG_CELL_SIZE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] sensor_x;
    logic [15:0] sensor_y;
    logic [15:0] point_height;
    logic [5:0]  query_col;
    logic [5:0]  query_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  cost;
    logic [16:0] slope_angle;
    logic        slope_known;
  } out_word_t;

  typedef struct packed {
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [4:0]  slope_radius;
    logic [16:0] fall_weight;
    logic [16:0] rise_weight;
    logic [16:0] caution_angle;
    logic [16:0] lethal_angle;
    logic [15:0] cell_size_mm;
  } cfg_t;

  // CORDIC request / response between sequencer and angle unit
  typedef struct packed {
    logic        start;
    logic [15:0] dz;
    logic [47:0] xdist;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] angle;
  } cordic_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_MUL,
    ST_ADD_CHK,
    ST_ADD_RD,
    ST_ADD_BLEND,
    ST_ADD_WR,
    ST_CLEAR,
    ST_Q_RD,
    ST_Q_CTR,
    ST_Q_NB,
    ST_Q_NBRD,
    ST_Q_XD,
    ST_Q_XD2,
    ST_Q_CORDIC,
    ST_Q_GRADE,
    ST_Q_DIV,
    ST_Q_OUT
  } state_t;

  function automatic logic [16:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 17'd51472;
      5'd1:  atan_entry = 17'd30385;
      5'd2:  atan_entry = 17'd16055;
      5'd3:  atan_entry = 17'd8150;
      5'd4:  atan_entry = 17'd4091;
      5'd5:  atan_entry = 17'd2047;
      5'd6:  atan_entry = 17'd1024;
      5'd7:  atan_entry = 17'd512;
      5'd8:  atan_entry = 17'd256;
      5'd9:  atan_entry = 17'd128;
      5'd10: atan_entry = 17'd64;
      5'd11: atan_entry = 17'd32;
      5'd12: atan_entry = 17'd16;
      5'd13: atan_entry = 17'd8;
      5'd14: atan_entry = 17'd4;
      5'd15: atan_entry = 17'd2;
      5'd16: atan_entry = 17'd1;
      default: atan_entry = 17'd0;
    endcase
  endfunction
endpackage

// File: sv/egsc_stream_if.sv
interface egsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/egsc_cfg_regs.sv
module egsc_cfg_regs
  import egsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);
  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);
  assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range     <= 16'd0;
      cfg_r.max_range     <= 16'hFFFF;
      cfg_r.slope_radius  <= 5'd4;
      cfg_r.fall_weight   <= 17'd65536;
      cfg_r.rise_weight   <= 17'd1311;
      cfg_r.caution_angle <= 17'd17157;
      cfg_r.lethal_angle  <= 17'd40034;
      cfg_r.cell_size_mm  <= 16'd50;
    end else if (wr) begin
      case (idx)
        REG_MIN_RANGE: cfg_r.min_range     <= pwdata[15:0];
        REG_MAX_RANGE: cfg_r.max_range     <= pwdata[15:0];
        REG_RADIUS:    cfg_r.slope_radius  <= pwdata[4:0];
        REG_FALL_W:    cfg_r.fall_weight   <= pwdata[16:0];
        REG_RISE_W:    cfg_r.rise_weight   <= pwdata[16:0];
        REG_CAUTION:   cfg_r.caution_angle <= pwdata[16:0];
        REG_LETHAL:    cfg_r.lethal_angle  <= pwdata[16:0];
        REG_CELL_SIZE: cfg_r.cell_size_mm  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_RANGE: prdata = {16'd0, cfg_r.min_range};
      REG_MAX_RANGE: prdata = {16'd0, cfg_r.max_range};
      REG_RADIUS:    prdata = {27'd0, cfg_r.slope_radius};
      REG_FALL_W:    prdata = {15'd0, cfg_r.fall_weight};
      REG_RISE_W:    prdata = {15'd0, cfg_r.rise_weight};
      REG_CAUTION:   prdata = {15'd0, cfg_r.caution_angle};
      REG_LETHAL:    prdata = {15'd0, cfg_r.lethal_angle};
      REG_CELL_SIZE: prdata = {16'd0, cfg_r.cell_size_mm};
      default:       prdata = 32'd0;
    endcase
  end
endmodule

// File: sv/egsc_cordic.sv
`include "assert_macros.svh"
module egsc_cordic
  import egsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);
  // x up to 2^48, y up to 2^32; grows by <2x during rotation
  logic signed [50:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [19:0] z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [50:0] xs, ys;
  logic signed [50:0] ax, ay;

  // shift truncating toward zero
  always_comb begin
    ax = x_r[50] ? -x_r : x_r;
    ay = y_r[50] ? -y_r : y_r;
    xs = x_r[50] ? -(ax >>> i_r) : (ax >>> i_r);
    ys = y_r[50] ? -(ay >>> i_r) : (ay >>> i_r);
  end

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      x_nxt = {3'd0, req.xdist};
      y_nxt = {19'd0, req.dz, 16'd0};
      z_nxt = '0; i_nxt = '0;
      busy_nxt = (req.dz != 16'd0);
      done_nxt = (req.dz == 16'd0);
    end else if (busy_r) begin
      if (!y_r[50]) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs;
        z_nxt = z_r + $signed({3'd0, atan_entry(i_r)});
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs;
        z_nxt = z_r - $signed({3'd0, atan_entry(i_r)});
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CordicSteps - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    if (z_r < 0) rsp.angle = '0;
    else if (z_r > 20'(AngleMax)) rsp.angle = 17'(AngleMax);
    else rsp.angle = z_r[16:0];
  end

  `ASSERT_NEXT(a_cordic_no_restart, clk, rst_n, busy_r, !req.start, "cordic restarted while busy")
  `ASSERT_CLK(a_cordic_done_idle, clk, rst_n, !(done_r && busy_r), "done while busy")
endmodule

// File: sv/egsc_seq.sv
`include "assert_macros.svh"
module egsc_seq
  import egsc_pkg::*;
#(
  parameter int unsigned GRID_W = GridWDef,
  parameter int unsigned GRID_H = GridHDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  output cordic_req_t creq,
  input  cordic_rsp_t crsp
);
  localparam int unsigned CW    = $clog2(GRID_W);
  localparam int unsigned RW    = $clog2(GRID_H);
  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned EW    = AW + 1;

  // Height memory: no reset, guarded by valid bits cleared by a sweep.
  logic [15:0] hmem [CELLS];
  logic        vmem [CELLS];
  logic [15:0] hrd_r;
  logic        vrd_r;
  logic [AW-1:0] raddr, waddr;
  logic        hwe, vwe, vwd;
  logic [15:0] hwd;

  always_ff @(posedge clk) begin
    if (hwe) hmem[waddr] <= hwd;
    if (vwe) vmem[waddr] <= vwd;
    hrd_r <= hmem[raddr];
    vrd_r <= vmem[raddr];
  end

  state_t state_r, state_nxt;
  in_word_t  item_r, item_nxt;
  out_word_t res_r, res_nxt;
  logic      ov_r, ov_nxt;
  logic [EW-1:0] ctr_r, ctr_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [16:0] best_r, best_nxt;
  logic        any_r, any_nxt;
  logic [33:0] acc_r, acc_nxt;   // shared multiplier product / scratch
  logic [47:0] xd_r, xd_nxt;
  logic [15:0] dz_r, dz_nxt;
  logic [AW-1:0] nidx_r, nidx_nxt;
  logic [8:0]  cost_r, cost_nxt;
  logic [26:0] rem_r, rem_nxt;
  logic [4:0]  dstep_r, dstep_nxt;

  // one shared 34x34 multiplier, operands chosen by state
  logic [33:0] ma, mb;
  logic [67:0] mp;
  assign mp = ma * mb;

  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  logic [33:0] d2;
  assign dx  = $signed({item_r.point_x[15], item_r.point_x})
             - $signed({item_r.sensor_x[15], item_r.sensor_x});
  assign dy  = $signed({item_r.point_y[15], item_r.point_y})
             - $signed({item_r.sensor_y[15], item_r.sensor_y});
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);

  logic [7:0] pcol, prow;
  assign pcol = item_r.point_x[15:8];
  assign prow = item_r.point_y[15:8];

  logic signed [6:0]  offx, offy;
  logic signed [11:0] ncx, ncy;
  always_comb begin
    case (k_r[2:0])
      3'd0: begin offx = 7'sd1;  offy = 7'sd0;  end
      3'd1: begin offx = -7'sd1; offy = 7'sd0;  end
      3'd2: begin offx = 7'sd0;  offy = 7'sd1;  end
      3'd3: begin offx = 7'sd0;  offy = -7'sd1; end
      3'd4: begin offx = 7'sd1;  offy = 7'sd1;  end
      3'd5: begin offx = 7'sd1;  offy = -7'sd1; end
      3'd6: begin offx = -7'sd1; offy = 7'sd1;  end
      default: begin offx = -7'sd1; offy = -7'sd1; end
    endcase
    ncx = $signed({6'd0, item_r.query_col}) + offx * $signed({7'd0, cfg.slope_radius});
    ncy = $signed({6'd0, item_r.query_row}) + offy * $signed({7'd0, cfg.slope_radius});
  end
  logic nb_in;
  assign nb_in = !ncx[11] && !ncy[11] && (ncx < 12'(GRID_W)) && (ncy < 12'(GRID_H));

  logic signed [16:0] delta;
  logic [16:0] adelta, wsel, wcl;
  assign delta  = $signed({item_r.point_height[15], item_r.point_height})
                - $signed({hrd_r[15], hrd_r});
  assign adelta = delta[16] ? 17'(-delta) : 17'(delta);
  assign wsel   = delta[16] ? cfg.fall_weight : cfg.rise_weight;
  assign wcl    = (wsel > 17'd65536) ? 17'd65536 : wsel;

  logic [16:0] span;
  assign span = cfg.lethal_angle - cfg.caution_angle;

  always_comb begin
    ma = '0; mb = '0;
    case (state_r)
      ST_ADD_MUL: begin ma = 34'(adx); mb = 34'(adx); end
      ST_ADD_CHK: begin ma = 34'(ady); mb = 34'(ady); end
      ST_ADD_BLEND: begin ma = 34'(wcl); mb = 34'(adelta); end
      ST_Q_XD: begin ma = 34'(cfg.cell_size_mm); mb = 34'(cfg.slope_radius); end
      ST_Q_XD2: begin
        ma = acc_r; mb = k_r[2] ? 34'(Sqrt2Q16) : 34'd65536;
      end
      ST_Q_GRADE: begin ma = 34'(best_r - cfg.caution_angle); mb = 34'd504; end
      default: ;
    endcase
  end

  logic [31:0] lo2, hi2;
  assign lo2 = cfg.min_range * cfg.min_range;
  assign hi2 = cfg.max_range * cfg.max_range;

  always_comb begin
    state_nxt = state_r; item_nxt = item_r; res_nxt = res_r; ov_nxt = ov_r;
    ctr_nxt = ctr_r; k_nxt = k_r; ch_nxt = ch_r; best_nxt = best_r;
    any_nxt = any_r; acc_nxt = acc_r; xd_nxt = xd_r; dz_nxt = dz_r;
    nidx_nxt = nidx_r; cost_nxt = cost_r; rem_nxt = rem_r; dstep_nxt = dstep_r;
    raddr = AW'(item_r.query_row) * AW'(GRID_W) + AW'(item_r.query_col);
    waddr = AW'(prow) * AW'(GRID_W) + AW'(pcol);
    hwe = 1'b0; vwe = 1'b0; vwd = 1'b1; hwd = item_r.point_height;
    creq = '0;
    d2 = '0;
    in_ready = (state_r == ST_IDLE) && !ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) begin
        item_nxt = in_data;
        case (action_t'(in_data.action))
          ACT_ADD:   state_nxt = ST_ADD_MUL;
          ACT_QUERY: state_nxt = ST_Q_RD;
          ACT_CLEAR: begin state_nxt = ST_CLEAR; ctr_nxt = '0; end
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_ADD_MUL: begin acc_nxt = mp[33:0]; state_nxt = ST_ADD_CHK; end
      ST_ADD_CHK: begin
        d2 = acc_r + mp[33:0];
        raddr = waddr;
        if (d2 < 34'(lo2) || d2 > 34'(hi2) || item_r.point_x[15] || item_r.point_y[15]
            || 32'(pcol) >= GRID_W || 32'(prow) >= GRID_H)
          state_nxt = ST_IDLE;
        else state_nxt = ST_ADD_RD;
      end
      ST_ADD_RD: begin
        raddr = waddr;
        if (!vrd_r) begin
          hwe = 1'b1; vwe = 1'b1; state_nxt = ST_IDLE;
        end else state_nxt = ST_ADD_BLEND;
      end
      ST_ADD_BLEND: begin
        acc_nxt = 34'((mp[33:0] + 34'd32768) >> 16);
        ch_nxt  = hrd_r;
        dz_nxt  = {15'd0, delta[16]};
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        hwe = 1'b1;
        hwd = dz_r[0] ? ch_r - acc_r[15:0] : ch_r + acc_r[15:0];
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        waddr = ctr_r[AW-1:0]; vwe = 1'b1; vwd = 1'b0;
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == EW'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_Q_RD: begin
        best_nxt = '0; any_nxt = 1'b0; k_nxt = '0;
        state_nxt = ST_Q_CTR;
      end
      ST_Q_CTR: begin
        ch_nxt = hrd_r;
        if (!vrd_r || 32'(item_r.query_col) >= GRID_W || 32'(item_r.query_row) >= GRID_H)
        begin
          res_nxt = '{cost: 8'd255, slope_angle: '0, slope_known: 1'b0};
          state_nxt = ST_Q_OUT;
        end else state_nxt = ST_Q_NB;
      end
      ST_Q_NB: begin
        if (k_r == 4'd8) begin
          if (!any_r) begin
            res_nxt = '{cost: 8'd255, slope_angle: '0, slope_known: 1'b0};
            state_nxt = ST_Q_OUT;
          end else state_nxt = ST_Q_GRADE;
        end else if (!nb_in || cfg.slope_radius == 0 || cfg.cell_size_mm == 0) begin
          k_nxt = k_r + 4'd1;
        end else begin
          nidx_nxt = AW'(ncy) * AW'(GRID_W) + AW'(ncx);
          state_nxt = ST_Q_NBRD;
        end
      end
      ST_Q_NBRD: begin
        raddr = nidx_r;
        state_nxt = ST_Q_XD;
      end
      ST_Q_XD: begin
        raddr = nidx_r;
        acc_nxt = mp[33:0];
        if (!vrd_r) begin k_nxt = k_r + 4'd1; state_nxt = ST_Q_NB; end
        else begin
          dz_nxt = (hrd_r >= ch_r) ^ (hrd_r[15] != ch_r[15])
                 ? 16'($signed(hrd_r) - $signed(ch_r))
                 : 16'($signed(ch_r) - $signed(hrd_r));
          state_nxt = ST_Q_XD2;
        end
      end
      ST_Q_XD2: begin
        xd_nxt = mp[47:0];
        creq.start = 1'b1;
        creq.dz = dz_r;
        creq.xdist = mp[47:0];
        state_nxt = ST_Q_CORDIC;
      end
      ST_Q_CORDIC: if (crsp.done) begin
        if (!any_r || crsp.angle > best_r) best_nxt = crsp.angle;
        any_nxt = 1'b1;
        k_nxt = k_r + 4'd1;
        state_nxt = ST_Q_NB;
      end
      ST_Q_GRADE: begin
        if (best_r >= cfg.lethal_angle) begin
          res_nxt = '{cost: 8'd254, slope_angle: best_r, slope_known: 1'b1};
          state_nxt = ST_Q_OUT;
        end else if (best_r <= cfg.caution_angle) begin
          res_nxt = '{cost: 8'd0, slope_angle: best_r, slope_known: 1'b1};
          state_nxt = ST_Q_OUT;
        end else begin
          // restoring division of (num) by 2*span, 9 quotient bits
          rem_nxt = 27'(mp[25:0]) + 27'(span);
          cost_nxt = '0; dstep_nxt = 5'd8;
          state_nxt = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (rem_r >= (27'({span, 1'b0}) << dstep_r)) begin
          rem_nxt = rem_r - (27'({span, 1'b0}) << dstep_r);
          cost_nxt = cost_r | (9'd1 << dstep_r);
        end
        dstep_nxt = dstep_r - 5'd1;
        if (dstep_r == 5'd0) state_nxt = ST_Q_DIV;
        if (dstep_r == 5'd0) begin
          res_nxt.slope_angle = best_r; res_nxt.slope_known = 1'b1;
          state_nxt = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (res_r.slope_known && res_r.cost != 8'd254 && res_r.cost != 8'd0
            && !(best_r >= cfg.lethal_angle) && !(best_r <= cfg.caution_angle))
          res_nxt.cost = cost_r[7:0];
        else if (res_r.slope_known && best_r > cfg.caution_angle
                 && best_r < cfg.lethal_angle)
          res_nxt.cost = cost_r[7:0];
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; ov_r <= 1'b0; ctr_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; ctr_r <= ctr_nxt;
    end
    item_r <= item_nxt; res_r <= res_nxt; k_r <= k_nxt; ch_r <= ch_nxt;
    best_r <= best_nxt; any_r <= any_nxt; acc_r <= acc_nxt; xd_r <= xd_nxt;
    dz_r <= dz_nxt; nidx_r <= nidx_nxt; cost_r <= cost_nxt; rem_r <= rem_nxt;
    dstep_r <= dstep_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `ASSERT_CLK(a_busy_no_accept, clk, rst_n, (state_r != ST_IDLE) |-> !in_ready, "accept while busy")
  `ASSERT_CLK(a_cost_range, clk, rst_n, out_valid |-> (out_data.cost <= 8'd252 || out_data.cost == 8'd254 || out_data.cost == 8'd255), "bad cost code")
endmodule

// File: sv/elevation_grid_slope_cost.sv
// Elevation grid slope cost: keeps a GRID_W x GRID_H grid of heights (mm) with
// valid flags, folds lidar points into it and grades the steepest slope around
// a queried cell into a costmap value (0 free .. 252, 254 lethal, 255 unknown).
// Items are handled one at a time; in_ready is low while one is in work and
// while a result word waits. A clear writes one valid flag per cycle over
// all GRID_W*GRID_H cells; a query grades each valid neighbour in range
// through the 17-step CORDIC angle unit shared by the eight neighbours. After
// reset the same sweep runs once before the first word is taken.
// Configuration sits on an APB port at byte address 4*index.
module elevation_grid_slope_cost
  import egsc_pkg::*;
#(
  parameter int unsigned GRID_W = GridWDef,
  parameter int unsigned GRID_H = GridHDef
) (
  input  logic                clk,
  input  logic                rst_n,
  egsc_stream_if.sink         in_if,
  egsc_stream_if.source       out_if,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  cfg_t        cfg;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  egsc_cfg_regs u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg
  );

  egsc_cordic u_cordic (.clk, .rst_n, .req(creq), .rsp(crsp));

  egsc_seq #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_seq (
    .clk, .rst_n, .cfg,
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
    .creq, .crsp
  );
endmodule

// File: test/tb_elevation_grid_slope_cost.sv
`timescale 1ns / 1ps

module tb_elevation_grid_slope_cost;
  import egsc_pkg::*;

  localparam int GW = 64;
  localparam int GH = 64;
  localparam int NCELL = GW * GH;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Run a two-phase clock at 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  egsc_stream_if #(.payload_t(in_word_t))  in_ch ();
  egsc_stream_if #(.payload_t(out_word_t)) out_ch ();

  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  elevation_grid_slope_cost u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------
  // Shadow of the block: configuration and the height grid.
  // ---------------------------------------------------------------------
  cfg_t        shadow_cfg;
  logic [15:0] grid_h [NCELL];
  bit          grid_v [NCELL];

  const int nb_dx[8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  const int nb_dy[8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  in_word_t  pending_words[$];
  out_word_t cost_fifo[$];
  int        err_count = 0;
  bit        feed_done = 1'b0;

  // Idling controls: no-idle stretch, long receiver hold, sender pause.
  bit calm = 1'b0;
  int hold_cycles = 0;
  bit sender_pause = 1'b0;

  // Load the default register values and clear the grid, as after reset.
  task automatic shadow_reset();
    shadow_cfg.min_range     = 16'd0;
    shadow_cfg.max_range     = 16'd65535;
    shadow_cfg.slope_radius  = 5'd4;
    shadow_cfg.fall_weight   = 17'd65536;
    shadow_cfg.rise_weight   = 17'd1311;
    shadow_cfg.caution_angle = 17'd17157;
    shadow_cfg.lethal_angle  = 17'd40034;
    shadow_cfg.cell_size_mm  = 16'd50;
    for (int i = 0; i < NCELL; i++) begin
      grid_v[i] = 1'b0;
      grid_h[i] = '0;
    end
  endtask

  function automatic longint trunc_shift(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC on (xdist, dz<<16), angle in 2^-16 rad.
  function automatic int unsigned cordic_angle(longint dz, longint xdist);
    const longint tab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint x, y, z, nx;
    x = xdist;
    y = dz <<< 16;
    z = 0;
    if (dz == 0) return 0;
    for (int i = 0; i < 17; i++) begin
      if (y >= 0) begin
        nx = x + trunc_shift(y, i);
        y  = y - trunc_shift(x, i);
        z += tab[i];
      end else begin
        nx = x - trunc_shift(y, i);
        y  = y + trunc_shift(x, i);
        z -= tab[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > AngleMax) z = AngleMax;
    return int'(z);
  endfunction

  // Fold one point into the shadow grid.
  task automatic fold_point(in_word_t w);
    longint px, py, dx, dy, d2, lo, hi, z, h, delta, mag, q;
    longint wt;
    int col, row, idx;
    px = longint'($signed(w.point_x));
    py = longint'($signed(w.point_y));
    dx = px - longint'($signed(w.sensor_x));
    dy = py - longint'($signed(w.sensor_y));
    d2 = dx * dx + dy * dy;
    lo = longint'(shadow_cfg.min_range) * shadow_cfg.min_range;
    hi = longint'(shadow_cfg.max_range) * shadow_cfg.max_range;
    if (d2 < lo || d2 > hi) return;
    if (px < 0 || py < 0) return;
    col = int'(px >> 8);
    row = int'(py >> 8);
    if (col >= GW || row >= GH) return;
    idx = row * GW + col;
    z = longint'($signed(w.point_height));
    if (!grid_v[idx]) begin
      grid_h[idx] = w.point_height;
      grid_v[idx] = 1'b1;
      return;
    end
    h = longint'($signed(grid_h[idx]));
    wt = (z < h) ? shadow_cfg.fall_weight : shadow_cfg.rise_weight;
    if (wt > 65536) wt = 65536;
    delta = z - h;
    mag = wt * ((delta < 0) ? -delta : delta);
    q = (mag + 32768) >> 16;
    grid_h[idx] = 16'((delta < 0) ? h - q : h + q);
  endtask

  // Work out the cost word of a query against the shadow grid.
  function automatic out_word_t grade_query(in_word_t w);
    out_word_t r;
    int col, row, rad, nc, nr, nidx;
    longint ch, dh, base, xd, span, num;
    int unsigned best, a;
    bit any;
    r.cost = 8'd255;
    r.slope_angle = '0;
    r.slope_known = 1'b0;
    col = w.query_col;
    row = w.query_row;
    rad = shadow_cfg.slope_radius;
    best = 0;
    any = 1'b0;
    if (!grid_v[row * GW + col]) return r;
    ch = longint'($signed(grid_h[row * GW + col]));
    for (int k = 0; k < 8; k++) begin
      nc = col + nb_dx[k] * rad;
      nr = row + nb_dy[k] * rad;
      if (nc < 0 || nr < 0 || nc >= GW || nr >= GH) continue;
      nidx = nr * GW + nc;
      if (!grid_v[nidx]) continue;
      base = longint'(shadow_cfg.cell_size_mm) * rad;
      if (base == 0) continue;
      xd = base * ((nb_dx[k] != 0 && nb_dy[k] != 0) ? Sqrt2Q16 : 65536);
      dh = longint'($signed(grid_h[nidx])) - ch;
      if (dh < 0) dh = -dh;
      a = cordic_angle(dh, xd);
      if (!any || a > best) best = a;
      any = 1'b1;
    end
    if (!any) return r;
    if (best >= shadow_cfg.lethal_angle) r.cost = 8'd254;
    else if (best <= shadow_cfg.caution_angle) r.cost = 8'd0;
    else begin
      span = longint'(shadow_cfg.lethal_angle) - shadow_cfg.caution_angle;
      num = (longint'(best) - shadow_cfg.caution_angle) * 504 + span;
      r.cost = 8'(num / (2 * span));
    end
    r.slope_angle = 17'(best);
    r.slope_known = 1'b1;
    return r;
  endfunction

  // Advance the shadow by one accepted word.
  task automatic predict_word(in_word_t w);
    case (action_t'(w.action))
      ACT_ADD:   fold_point(w);
      ACT_QUERY: cost_fifo.push_back(grade_query(w));
      ACT_CLEAR: for (int i = 0; i < NCELL; i++) grid_v[i] = 1'b0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer words from the pending queue, idle at random.
  // ---------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      bit fire;
      bit offer;
      fire = in_ch.valid && in_ch.ready;
      if (fire) predict_word(in_ch.data);
      // Hold a word that was not taken; otherwise pick the next one.
      if (!in_ch.valid || fire) begin
        if (fire) void'(pending_words.pop_front());
        offer = pending_words.size() > 0 && !sender_pause &&
                (calm || $urandom_range(99) >= 12);
        in_ch.valid <= offer;
        if (offer) in_ch.data <= pending_words[0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: accept result words and compare with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_word_t want;
        if (cost_fifo.size() == 0) begin
          report_mismatch("unexpected word", out_ch.data, 0);
        end else begin
          want = cost_fifo.pop_front();
          if (out_ch.data.cost != want.cost)
            report_mismatch("cost", out_ch.data.cost, want.cost);
          if (out_ch.data.slope_angle != want.slope_angle)
            report_mismatch("slope_angle", out_ch.data.slope_angle, want.slope_angle);
          if (out_ch.data.slope_known != want.slope_known)
            report_mismatch("slope_known", out_ch.data.slope_known, want.slope_known);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 12;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CfgAddrW'(4 * idx);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MIN_RANGE: shadow_cfg.min_range     = val[15:0];
      REG_MAX_RANGE: shadow_cfg.max_range     = val[15:0];
      REG_RADIUS:    shadow_cfg.slope_radius  = val[4:0];
      REG_FALL_W:    shadow_cfg.fall_weight   = val[16:0];
      REG_RISE_W:    shadow_cfg.rise_weight   = val[16:0];
      REG_CAUTION:   shadow_cfg.caution_angle = val[16:0];
      REG_LETHAL:    shadow_cfg.lethal_angle  = val[16:0];
      default:       shadow_cfg.cell_size_mm  = val[15:0];
    endcase
  endtask

  // Wait until every word is in and answered, then let a clear sweep finish.
  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || cost_fifo.size() > 0)
      @(posedge clk);
    repeat (NCELL + 300) @(posedge clk);
  endtask

  function automatic in_word_t make_word(action_t act, int px, int py, int sx, int sy,
                                         int hz, int qc, int qr);
    in_word_t w;
    w.action = act;
    w.point_x = 16'(px);
    w.point_y = 16'(py);
    w.sensor_x = 16'(sx);
    w.sensor_y = 16'(sy);
    w.point_height = 16'(hz);
    w.query_col = 6'(qc);
    w.query_row = 6'(qr);
    return w;
  endfunction

  // Point onto a cell inside a small window; the sensor position is random.
  function automatic in_word_t rand_point(int c0, int span);
    int c, r;
    c = c0 + $urandom_range(span - 1);
    r = c0 + $urandom_range(span - 1);
    return make_word(ACT_ADD, c * 256 + $urandom_range(255), r * 256 + $urandom_range(255),
                     $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(600) - 300, 0, 0);
  endfunction

  function automatic in_word_t rand_noise();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  // One random phase: mostly points and queries on a dense window.
  task automatic random_phase(int count, int c0, int span);
    in_word_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) w = rand_point(c0, span);
      else if (pick < 90)
        w = make_word(ACT_QUERY, 0, 0, 0, 0, 0,
                      c0 + $urandom_range(span - 1), c0 + $urandom_range(span - 1));
      else if (pick < 92) w = make_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      else w = rand_noise();
      // Keep the sensor at the point for most points so the range passes.
      if (pick < 45) begin
        w.sensor_x = w.point_x;
        w.sensor_y = w.point_y;
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of fields, every action, off-map drops.
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 63, 63));
    pending_words.push_back(make_word(ACT_ADD, 10 * 256, 10 * 256, 10 * 256, 10 * 256,
                                      32767, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 10, 10));
    pending_words.push_back(make_word(ACT_ADD, 14 * 256, 10 * 256, 14 * 256, 10 * 256,
                                      -32768, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 14 * 256 + 255, 14 * 256 + 255, 0, 0,
                                      100, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 6 * 256, 6 * 256, 6 * 256, 6 * 256, 0, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 10, 10));
    pending_words.push_back(make_word(ACT_ADD, 10 * 256, 10 * 256, 10 * 256, 10 * 256,
                                      -32768, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 10 * 256, 10 * 256, 10 * 256, 10 * 256,
                                      32767, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 14, 10));
    pending_words.push_back(make_word(ACT_ADD, -1, 5, -1, 5, 7, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 32767, 32767, 32767, 32767, 7, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 63 * 256 + 255, 63 * 256, 63 * 256, 63 * 256,
                                      5, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 0, 0, -32768, -32768, 5, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 63, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ACT_NONE, 0, 0, 0, 0, 0, 1, 1));
    pending_words.push_back(make_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 10, 10));
    drain();

    // Zero radius and tight range: neighbours skipped, the zero-range point dropped.
    cfg_write(REG_RADIUS, 0);
    cfg_write(REG_MIN_RANGE, 300);
    cfg_write(REG_MAX_RANGE, 400);
    pending_words.push_back(make_word(ACT_ADD, 5 * 256, 5 * 256, 5 * 256, 5 * 256, 1, 0, 0));
    pending_words.push_back(make_word(ACT_ADD, 5 * 256, 5 * 256, 5 * 256 - 350, 5 * 256,
                                      1, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0, 0, 0, 0, 5, 5));
    drain();

    // Phase A: defaults apart from radius, no idling with a long receiver hold.
    cfg_write(REG_MIN_RANGE, 0);
    cfg_write(REG_MAX_RANGE, 65535);
    cfg_write(REG_RADIUS, 1);
    calm = 1'b1;
    random_phase(120, 20, 4);
    hold_cycles = 3000;
    drain();
    calm = 1'b0;

    // Phase B: extreme weights and angles, large radius.
    cfg_write(REG_FALL_W, 0);
    cfg_write(REG_RISE_W, 131071);
    cfg_write(REG_CAUTION, 0);
    cfg_write(REG_LETHAL, 102944);
    cfg_write(REG_CELL_SIZE, 1);
    cfg_write(REG_RADIUS, 31);
    random_phase(100, 0, 64);
    random_phase(60, 16, 32);
    drain();

    // Phase C: equal thresholds, extreme weights, largest cells.
    cfg_write(REG_FALL_W, 131071);
    cfg_write(REG_RISE_W, 0);
    cfg_write(REG_CAUTION, 102944);
    cfg_write(REG_LETHAL, 102944);
    cfg_write(REG_CELL_SIZE, 65535);
    cfg_write(REG_RADIUS, 2);
    random_phase(150, 30, 6);
    drain();

    // Sender pause until all answered, then phase D with random registers.
    sender_pause = 1'b1;
    drain();
    sender_pause = 1'b0;
    cfg_write(REG_FALL_W, $urandom_range(65536));
    cfg_write(REG_RISE_W, $urandom_range(65536));
    cfg_write(REG_CAUTION, $urandom_range(30000));
    cfg_write(REG_LETHAL, 30001 + $urandom_range(60000));
    cfg_write(REG_CELL_SIZE, 1 + $urandom_range(200));
    cfg_write(REG_RADIUS, 1 + $urandom_range(3));
    cfg_write(REG_MIN_RANGE, $urandom_range(200));
    cfg_write(REG_MAX_RANGE, 20000 + $urandom_range(45535));
    random_phase(270, 40, 10);
    drain();
    feed_done = 1'b1;

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Generous limit: clear sweeps dominate the slowest run.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
